// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros for the modular inverse search block.
// Every macro samples on the rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MIBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MIBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mibs_pkg.sv =====
// Shared constants, status codes and control structs for the modular inverse search.
// No dependencies.
package mibs_pkg;

    localparam int WIDTH_DEF = 16;
    localparam int STAT_W    = 2;

    localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd2;

    // Sequencer to datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic srch_init;
        logic srch_step;
    } t_dp_ctl;

    // Datapath to sequencer.
    typedef struct packed {
        logic rem_zero;
        logic k_last;
    } t_dp_flg;

endpackage

// ===== rtl/core/mibs_if.sv =====
// Valid/ready channel interfaces for operand and result words.
// Depends on mibs_pkg.
interface mibs_in_if #(
    parameter int W = mibs_pkg::WIDTH_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] number;
    logic [W-1:0] modulus;

    modport source (output valid, output number, output modulus, input ready);
    modport sink   (input valid, input number, input modulus, output ready);
endinterface

interface mibs_out_if #(
    parameter int W = mibs_pkg::WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [W-1:0]                  inverse;
    logic [mibs_pkg::STAT_W-1:0]   status;

    modport source (output valid, output inverse, output status, input ready);
    modport sink   (input valid, input inverse, input status, output ready);
endinterface

// ===== rtl/core/mibs_dp.sv =====
// Datapath: one shared add/compare/subtract unit, used first as a restoring divider
// (modulus / number) and then to step the remainder and quotient of modulus*k+1. Uses mibs_pkg.
module mibs_dp #(
    parameter int WIDTH = mibs_pkg::WIDTH_DEF
) (
    input  logic                i_clk,
    input  mibs_pkg::t_dp_ctl   i_ctl,
    input  logic [WIDTH-1:0]    i_number,
    input  logic [WIDTH-1:0]    i_modulus,
    output mibs_pkg::t_dp_flg   o_flg,
    output logic [WIDTH-1:0]    o_quot
);

    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] r_r;     // partial remainder, then remainder of modulus*k+1
    logic [WIDTH-1:0] r_q;     // dividend/quotient shifter, then quotient of modulus*k+1
    logic [WIDTH-1:0] r_mq;
    logic [WIDTH-1:0] r_mr;
    logic [WIDTH-1:0] r_k;

    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;
    logic             w_one;
    logic [WIDTH-1:0] n_r;

    // Shared unit: sum, compare against number, conditional subtract.
    always_comb begin
        if (i_ctl.div_step) begin
            w_sum = {r_r, r_q[WIDTH-1]};
        end else begin
            w_sum = {1'b0, r_r} + {1'b0, r_mr};
        end
        w_ge   = (w_sum >= {1'b0, r_num});
        w_diff = w_sum - {1'b0, r_num};
        n_r    = w_ge ? w_diff[WIDTH-1:0] : w_sum[WIDTH-1:0];
        w_one  = (r_num == WIDTH'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_num <= i_number;
            r_q   <= i_modulus;
            r_r   <= '0;
        end else if (i_ctl.div_step) begin
            r_r <= n_r;
            r_q <= {r_q[WIDTH-2:0], w_ge};
        end else if (i_ctl.srch_init) begin
            // keep modulus = mq*number + mr; start from 1 = q*number + r
            r_mq <= r_q;
            r_mr <= r_r;
            r_r  <= w_one ? '0 : WIDTH'(1);
            r_q  <= w_one ? WIDTH'(1) : '0;
            r_k  <= '0;
        end else if (i_ctl.srch_step) begin
            r_r <= n_r;
            r_q <= r_q + r_mq + WIDTH'(w_ge);
            r_k <= r_k + WIDTH'(1);
        end
    end

    assign o_flg.rem_zero = (r_r == '0);
    assign o_flg.k_last   = (r_k == r_num - WIDTH'(1));
    assign o_quot         = r_q;

endmodule

// ===== rtl/core/mibs_ctrl.sv =====
// Sequencer: load, WIDTH division steps, search init, one search step per cycle, finish.
// Uses mibs_pkg; drives mibs_dp.
module mibs_ctrl #(
    parameter int WIDTH = mibs_pkg::WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_zero,
    input  logic                          i_out_free,
    input  mibs_pkg::t_dp_flg             i_flg,
    output mibs_pkg::t_dp_ctl             o_ctl,
    output logic                          o_idle,
    output logic                          o_fin,
    output logic [mibs_pkg::STAT_W-1:0]   o_status
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_INIT,
        S_SRCH,
        S_FIN
    } t_state;

    t_state                        r_state;
    logic [CNT_W-1:0]              r_dcnt;
    logic [mibs_pkg::STAT_W-1:0]   r_status;
    logic                          w_div_last;

    assign w_div_last = (r_dcnt == CNT_W'(WIDTH - 1));

    always_comb begin
        o_ctl = '0;
        case (r_state)
            S_IDLE:  o_ctl.load      = i_start;
            S_DIV:   o_ctl.div_step  = 1'b1;
            S_INIT:  o_ctl.srch_init = 1'b1;
            S_SRCH:  o_ctl.srch_step = !i_flg.rem_zero && !i_flg.k_last;
            default: o_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dcnt   <= '0;
            r_status <= mibs_pkg::ST_FOUND;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dcnt <= '0;
                        if (i_zero) begin
                            r_status <= mibs_pkg::ST_ZERO;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + CNT_W'(1);
                    if (w_div_last) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (i_flg.rem_zero) begin
                        r_status <= mibs_pkg::ST_FOUND;
                        r_state  <= S_FIN;
                    end else if (i_flg.k_last) begin
                        r_status <= mibs_pkg::ST_NONE;
                        r_state  <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register can take the word
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_fin    = (r_state == S_FIN);
    assign o_status = r_status;

endmodule

// ===== rtl/core/modular_inverse_brute_search_unit.sv =====
// Modular inverse by search; uses mibs_pkg, mibs_if, mibs_dp, mibs_ctrl, assert_macros.svh.
// A zero number goes straight to finish; otherwise the block divides, runs the search init,
// then searches k from zero up to number - 1 and finishes.
// Throughput: one item at a time, not ready while busy; the next word can be taken in the
// same cycle the result word is first offered; finish holds while the result register is full and unread.
// Reset (synchronous, active low) clears the sequencer and the output valid only.
`include "assert_macros.svh"

module modular_inverse_brute_search_unit #(
    parameter int WIDTH = mibs_pkg::WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mibs_in_if.sink           i_in,
    mibs_out_if.source        o_out
);

    mibs_pkg::t_dp_ctl             w_ctl;
    mibs_pkg::t_dp_flg             w_flg;
    logic [WIDTH-1:0]              w_quot;
    logic                          w_idle;
    logic                          w_fin;
    logic [mibs_pkg::STAT_W-1:0]   w_status;
    logic                          w_start;
    logic                          w_out_free;
    logic                          w_capture;

    logic                          r_ovalid;
    logic [WIDTH-1:0]              r_oinv;
    logic [mibs_pkg::STAT_W-1:0]   r_ostat;

    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_capture  = w_fin && w_out_free;

    mibs_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_zero     (i_in.number == '0),
        .i_out_free (w_out_free),
        .i_flg      (w_flg),
        .o_ctl      (w_ctl),
        .o_idle     (w_idle),
        .o_fin      (w_fin),
        .o_status   (w_status)
    );

    mibs_dp #(.WIDTH(WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_number  (i_in.number),
        .i_modulus (i_in.modulus),
        .o_flg     (w_flg),
        .o_quot    (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_capture) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_ostat <= w_status;
            r_oinv  <= (w_status == mibs_pkg::ST_FOUND) ? w_quot : '0;
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.inverse = r_oinv;
    assign o_out.status  = r_ostat;

    `MIBS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "accepted a word while busy")
    `MIBS_ASSERT_IMP(a_fail_inv_zero, i_clk, i_rst_n, r_ovalid && (r_ostat != mibs_pkg::ST_FOUND), r_oinv == '0, "nonzero inverse with failure status")
    `MIBS_ASSERT_NXT(a_capture_valid, i_clk, i_rst_n, w_capture, r_ovalid && !w_fin, "result word not posted")

endmodule

// ===== dv/tb_modular_inverse_brute_search_unit.sv =====
// Testbench for modular_inverse_brute_search_unit: sends operand words, predicts each
// inverse and status by its own search and checks every result word in order.
// Depends on mibs_pkg, mibs_if and the RTL of the search unit.
`timescale 1ns / 100ps

module tb_modular_inverse_brute_search_unit;

    localparam int W = mibs_pkg::WIDTH_DEF;

    typedef struct packed {
        logic [W-1:0]                inverse;
        logic [mibs_pkg::STAT_W-1:0] status;
    } t_inv_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mibs_in_if  #(.W(W)) in_ch ();
    mibs_out_if #(.W(W)) out_ch ();

    modular_inverse_brute_search_unit #(.WIDTH(W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_inv_result pending_results[$];
    int          fail_count    = 0;
    int          sent_count    = 0;
    int          found_count   = 0;
    int          none_count    = 0;
    int          zero_count    = 0;
    bit          no_idle       = 1'b0;
    int          hold_request  = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Search multipliers k until modulus*k + 1 divides by number, at most number tries.
    function automatic t_inv_result search_inverse(input logic [W-1:0] num,
                                                   input logic [W-1:0] modl);
        t_inv_result     r;
        longint unsigned m;
        longint unsigned n;
        longint unsigned cand;
        longint unsigned k;
        bit              hit;
        r.inverse = '0;
        m = modl;
        n = num;
        hit = 1'b0;
        if (num == '0) begin
            r.status = mibs_pkg::ST_ZERO;
        end else begin
            for (k = 0; k < n && !hit; k++) begin
                cand = m * k + 1;
                if (cand % n == 0) begin
                    r.inverse = W'(cand / n);
                    hit = 1'b1;
                end
            end
            r.status = hit ? mibs_pkg::ST_FOUND : mibs_pkg::ST_NONE;
        end
        return r;
    endfunction

    // Half no gap, most of the rest short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Called at a rising edge; returns at the edge that accepts the word, or after the gap.
    task automatic send_operands(input logic [W-1:0] num, input logic [W-1:0] modl);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.number  <= num;
        in_ch.modulus <= modl;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(search_inverse(num, modl));
        sent_count++;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid   <= 1'b0;
            in_ch.number  <= W'($urandom);
            in_ch.modulus <= W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: long hold on request, always ready while no_idle is set, otherwise random stalls.
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (no_idle) begin
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare each accepted result word with the oldest prediction.
    initial begin
        t_inv_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result word: inverse %0d status %0d",
                           out_ch.inverse, out_ch.status);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.inverse !== want.inverse) begin
                        $error("inverse: expected %0d, actual %0d", want.inverse,
                               out_ch.inverse);
                        fail_count++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                               out_ch.status);
                        fail_count++;
                    end
                    case (want.status)
                        mibs_pkg::ST_FOUND: found_count++;
                        mibs_pkg::ST_NONE:  none_count++;
                        default:            zero_count++;
                    endcase
                end
            end
        end
    end

    task automatic test_directed_edges();
        send_operands(16'd0, 16'd0);          // zero number
        send_operands(16'd0, 16'hFFFF);
        send_operands(16'd1, 16'd0);          // number one, modulus zero
        send_operands(16'd1, 16'd1);
        send_operands(16'd1, 16'hFFFF);
        send_operands(16'd2, 16'd0);          // modulus zero, no inverse
        send_operands(16'd3, 16'd1);          // modulus one gives quotient 1
        send_operands(16'd5, 16'd1);
        send_operands(16'd3, 16'd7);
        send_operands(16'd7, 16'd10);
        send_operands(16'd10, 16'd7);
        send_operands(16'd6, 16'd4);          // shared factor
        send_operands(16'd12, 16'd18);
        send_operands(16'd4, 16'd6);
        send_operands(16'h00FF, 16'hFF00);
        send_operands(16'h8000, 16'hFFFF);
        send_operands(16'hFFFF, 16'hFFFE);
        send_operands(16'hFFFF, 16'd2);
        send_operands(16'hFFFF, 16'hFFFF);    // full-length search, no inverse
        send_operands(16'hFFFF, 16'd0);
        send_operands(16'h5555, 16'hAAAA);
    endtask

    // Hold the result side while the sender keeps offering words.
    task automatic test_output_backpressure();
        no_idle      = 1'b1;
        hold_request = 300;
        for (int i = 0; i < 4; i++)
            send_operands(W'($urandom_range(1, 63)), W'($urandom_range(0, 65535)));
        no_idle = 1'b0;
    endtask

    task automatic test_random_mix(input int count);
        int           r;
        int           f;
        logic [W-1:0] num;
        logic [W-1:0] modl;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                num  = '0;
                modl = W'($urandom_range(0, 65535));
            end else if (r < 30) begin
                f    = $urandom_range(2, 16);
                num  = W'(f * $urandom_range(1, 63));
                modl = W'(f * $urandom_range(0, 65535 / f));
            end else if (r < 35) begin
                num  = W'($urandom_range(1024, 65535));
                modl = W'($urandom_range(0, 65535));
            end else if (r < 40) begin
                num  = W'($urandom_range(1, 1023));
                modl = W'($urandom_range(0, 1));
            end else begin
                num  = W'($urandom_range(1, 1023));
                modl = W'($urandom_range(0, 65535));
            end
            send_operands(num, modl);
        end
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        for (int i = 0; i < count; i++)
            send_operands(W'($urandom_range(0, 200)), W'($urandom_range(0, 65535)));
        no_idle = 1'b0;
    endtask

    initial begin
        int settle;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.number  <= '0;
        in_ch.modulus <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_output_backpressure();
        test_random_mix(65);
        test_back_to_back(10);
        in_ch.valid <= 1'b0;

        settle = 0;
        while (pending_results.size() != 0 && settle < 150000) begin
            @(posedge i_clk);
            settle++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            $display("status: fail");
            $finish;
        end else begin
            // Catch any stray word after the last one.
            repeat (40) @(posedge i_clk);
            $display("sent %0d operand words: %0d inverses found, %0d without inverse,",
                     sent_count, found_count, none_count);
            $display("%0d zero numbers, with random gaps, stalls and one long hold-off",
                     zero_count);
            if (fail_count == 0) begin
                $display("status: pass");
            end else begin
                $display("status: fail");
            end
            $finish;
        end
    end

    initial begin
        #400000000;
        $error("run did not finish in time");
        $display("status: fail");
        $finish;
    end

endmodule
